// ===== design/hsla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsla_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_HUE_SHIFT  = 2'd0;
  localparam logic [1:0] REG_SAT_GAIN   = 2'd1;
  localparam logic [1:0] REG_LIGHT_GAIN = 2'd2;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 10;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic signed [9:0] hue_shift;
    logic signed [9:0] saturation_gain;
    logic signed [9:0] lightness_gain;
  } cfg_t;

  // classified pixel: two long divisions in flight plus lightness
  typedef struct packed {
    logic [7:0]  rem_s;
    logic [16:0] num_s;
    logic [16:0] quo_s;
    logic [7:0]  dvs_s;
    logic [7:0]  rem_h;
    logic [16:0] num_h;
    logic [16:0] quo_h;
    logic [7:0]  dvs_h;
    logic [16:0] light;
    logic        grey;
  } div_t;

endpackage : hsla_pkg

`default_nettype wire

// ===== design/hsla_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsla_front
  import hsla_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire pix_in_t pix_i,
  output logic         full_o,
  output logic         qpush_o,
  output div_t         qdata_o,
  input  wire logic    qfull_i
);

  logic [7:0]  r, g, b, mx, mn, d, den;
  logic [8:0]  sm;
  logic [10:0] n, d6;
  logic [24:0] hn;
  logic [33:0] lp;
  logic        move;
  div_t        f_d, f_q;
  logic        f_vld_q;

  // min / max and hue sector
  always_comb begin
    r  = pix_i.red_in;
    g  = pix_i.green_in;
    b  = pix_i.blue_in;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;
    sm = 9'(mx) + 9'(mn);
    d6 = (11'(d) << 2) + (11'(d) << 1);
    priority if (mx == r) begin
      n = 11'(g) - 11'(b) + ((g < b) ? d6 : 11'd0);
    end else if (mx == g) begin
      n = 11'(b) - 11'(r) + (11'(d) << 1);
    end else begin
      n = 11'(r) - 11'(g) + (11'(d) << 2);
    end
    den = (sm <= 9'd255) ? sm[7:0] : 8'(9'd510 - sm);
    // n * 15360 and lightness sm * 65536 / 510 by reciprocal
    hn  = (25'(n) << 14) - (25'(n) << 10);
    lp  = 34'(sm) * 34'd16843010;
  end

  // seed the two dividers
  always_comb begin
    f_d.rem_s = {1'b0, d[7:1]};
    f_d.num_s = {d[0], 16'd0};
    f_d.quo_s = '0;
    f_d.dvs_s = den;
    f_d.rem_h = hn[24:17];
    f_d.num_h = hn[16:0];
    f_d.quo_h = '0;
    f_d.dvs_h = d;
    f_d.light = lp[33:17];
    f_d.grey  = (d == 8'd0);
  end

  assign move    = !f_vld_q || !qfull_i;
  assign full_o  = !move;
  assign qpush_o = f_vld_q && !qfull_i;
  assign qdata_o = f_q;

  // input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (move) begin
      f_vld_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && push_i) begin
      f_q <= f_d;
    end
  end

endmodule : hsla_front

`default_nettype wire

// ===== design/hsla_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsla_queue
  import hsla_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire div_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output div_t      data_o
);

  div_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      if (wr && !rd) cnt_q <= cnt_q + 3'd1;
      else if (rd && !wr) cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule : hsla_queue

`default_nettype wire

// ===== design/hsla_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsla_back
  import hsla_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     qempty_i,
  input  wire div_t     qdata_i,
  output logic          qpop_o,
  output logic          empty_o,
  input  wire logic     pop_i,
  output pix_out_t      pix_o
);

  localparam int unsigned NDiv = 17;
  localparam int unsigned NSt  = NDiv + 7;
  localparam int unsigned SG   = NDiv + 6;

  localparam logic signed [18:0] HueFull = 19'sd92160;
  localparam logic signed [18:0] HueTwo  = 19'sd184320;
  localparam logic [17:0]        Third   = 18'd30720;
  localparam logic [17:0]        Full18  = 18'd92160;
  localparam logic [52:0]        Rcp100  = 53'd85899346;
  localparam logic [42:0]        Rcp15   = 43'd4473925;

  // one restoring step of both dividers
  function automatic div_t div_step(div_t x);
    div_t       y;
    logic [8:0] ts, th;
    y  = x;
    ts = {x.rem_s, x.num_s[16]};
    th = {x.rem_h, x.num_h[16]};
    if (ts >= {1'b0, x.dvs_s}) begin
      y.rem_s = 8'(ts - {1'b0, x.dvs_s});
      y.quo_s = {x.quo_s[15:0], 1'b1};
    end else begin
      y.rem_s = ts[7:0];
      y.quo_s = {x.quo_s[15:0], 1'b0};
    end
    if (th >= {1'b0, x.dvs_h}) begin
      y.rem_h = 8'(th - {1'b0, x.dvs_h});
      y.quo_h = {x.quo_h[15:0], 1'b1};
    end else begin
      y.rem_h = th[7:0];
      y.quo_h = {x.quo_h[15:0], 1'b0};
    end
    y.num_s = {x.num_s[15:0], 1'b0};
    y.num_h = {x.num_h[15:0], 1'b0};
    return y;
  endfunction

  // x * (100 + gain) / 100, floored at zero and clamped to one
  function automatic logic [16:0] gain_scale(logic signed [28:0] pr);
    logic [52:0] m;
    m = 53'(pr[25:0]) * Rcp100;
    if (pr <= 29'sd0) return 17'd0;
    if (m[52:33] > 20'd65536) return 17'd65536;
    return m[49:33];
  endfunction

  function automatic logic [7:0] to_byte(logic [16:0] v);
    logic [24:0] m;
    m = (25'(v) << 8) - 25'(v);
    return (m[24:16] > 9'd255) ? 8'd255 : m[23:16];
  endfunction

  // hue position to ramp factor, 15360 means full q
  function automatic logic [13:0] ramp(logic [16:0] t);
    if (t < 17'd15360) return t[13:0];
    if (t < 17'd46080) return 14'd15360;
    if (t < 17'd61440) return 14'(17'd61440 - t);
    return 14'd0;
  endfunction

  logic [NSt-1:0] vld_q;
  logic           en, oq_full, oq_wr, oq_rd, in_pop;
  div_t           dv_q [NDiv];

  // result queue state
  pix_out_t   oq_mem_q [4];
  logic [1:0] oq_wp_q, oq_rp_q;
  logic [2:0] oq_cnt_q;

  assign oq_full = (oq_cnt_q == 3'd4);
  assign en      = !(vld_q[SG] && oq_full);
  assign in_pop  = en && !qempty_i;
  assign qpop_o  = in_pop;

  // valid bits travel with the transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSt-2:0], in_pop};
    end
  end

  // divider stages, one quotient bit each
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= div_step(qdata_i);
    end
  end

  for (genvar k = 1; k < NDiv; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k] <= div_step(dv_q[k-1]);
      end
    end
  end

  // stage a: hue shift and wrap, gain products
  logic [16:0]        h_raw, s_raw, a_hue_q;
  logic signed [18:0] hsum, hw;
  logic signed [10:0] gs, gl;
  logic signed [28:0] a_ps_q, a_pl_q;

  always_comb begin
    h_raw = dv_q[NDiv-1].grey ? 17'd0 : dv_q[NDiv-1].quo_h;
    s_raw = dv_q[NDiv-1].grey ? 17'd0 : dv_q[NDiv-1].quo_s;
    hsum  = $signed({2'b00, h_raw})
          + ($signed({{9{cfg_i.hue_shift[9]}}, cfg_i.hue_shift}) <<< 8);
    priority if (hsum < -HueFull) hw = hsum + HueTwo;
    else if (hsum < 19'sd0)       hw = hsum + HueFull;
    else if (hsum >= HueTwo)      hw = hsum - HueTwo;
    else if (hsum >= HueFull)     hw = hsum - HueFull;
    else                          hw = hsum;
    gs = $signed({cfg_i.saturation_gain[9], cfg_i.saturation_gain}) + 11'sd100;
    gl = $signed({cfg_i.lightness_gain[9], cfg_i.lightness_gain}) + 11'sd100;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_hue_q <= hw[16:0];
      a_ps_q  <= $signed({1'b0, s_raw}) * gs;
      a_pl_q  <= $signed({1'b0, dv_q[NDiv-1].light}) * gl;
    end
  end

  // stage b: divide by 100 and clamp
  logic [16:0] b_s_q, b_l_q, b_hue_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_s_q   <= gain_scale(a_ps_q);
      b_l_q   <= gain_scale(a_pl_q);
      b_hue_q <= a_hue_q;
    end
  end

  // stage c: l*s and channel angles
  logic [33:0] ls_prod;
  logic [17:0] ta, tb;
  logic [16:0] c_s_q, c_l_q, c_ls_q;
  logic [16:0] c_t_q [3];
  logic        c_grey_q;

  always_comb begin
    ls_prod = 34'(b_l_q) * 34'(b_s_q);
    ta      = 18'(b_hue_q) + Third;
    if (ta > Full18) ta = ta - Full18;
    tb = (18'(b_hue_q) < Third) ? 18'(b_hue_q) + Full18 - Third
                                : 18'(b_hue_q) - Third;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_s_q    <= b_s_q;
      c_l_q    <= b_l_q;
      c_ls_q   <= ls_prod[32:16];
      c_grey_q <= (b_s_q == 17'd0);
      c_t_q[0] <= ta[16:0];
      c_t_q[1] <= b_hue_q;
      c_t_q[2] <= tb[16:0];
    end
  end

  // stage d: q, p and ramp factors
  logic signed [19:0] qv, pv;
  logic [16:0]        pc;
  logic [17:0]        d_diff_q;
  logic [16:0]        d_p_q, d_l_q;
  logic [13:0]        d_f_q [3];
  logic               d_grey_q;

  always_comb begin
    if (c_l_q < 17'd32768) begin
      qv = $signed({3'b000, c_l_q}) + $signed({3'b000, c_ls_q});
    end else begin
      qv = $signed({3'b000, c_l_q}) + $signed({3'b000, c_s_q})
         - $signed({3'b000, c_ls_q});
    end
    pv = ($signed({3'b000, c_l_q}) <<< 1) - qv;
    pc = (pv < 20'sd0) ? 17'd0 : pv[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_diff_q <= 18'(qv - $signed({3'b000, pc}));
      d_p_q    <= pc;
      d_l_q    <= c_l_q;
      d_grey_q <= c_grey_q;
      for (int i = 0; i < 3; i++) begin
        d_f_q[i] <= ramp(c_t_q[i]);
      end
    end
  end

  // stage e: (q - p) * factor, pre-shifted by 1024
  logic [31:0] mul_e [3];
  logic [19:0] e_y_q [3];
  logic [16:0] e_p_q, e_l_q;
  logic        e_grey_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_e[i] = 32'(d_diff_q) * 32'(d_f_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_y_q[i] <= mul_e[i][29:10];
      end
      e_p_q    <= d_p_q;
      e_l_q    <= d_l_q;
      e_grey_q <= d_grey_q;
    end
  end

  // stage f: divide by 15 and add p
  logic [42:0] mul_f [3];
  logic [16:0] f_v_q [3];
  logic [16:0] f_l_q;
  logic        f_grey_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_f[i] = 43'(e_y_q[i]) * Rcp15;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_v_q[i] <= e_p_q + mul_f[i][42:26];
      end
      f_l_q    <= e_l_q;
      f_grey_q <= e_grey_q;
    end
  end

  // stage g: back to bytes
  pix_out_t g_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q.red_out   <= to_byte(f_grey_q ? f_l_q : f_v_q[0]);
      g_q.green_out <= to_byte(f_grey_q ? f_l_q : f_v_q[1]);
      g_q.blue_out  <= to_byte(f_grey_q ? f_l_q : f_v_q[2]);
    end
  end

  // result queue
  assign empty_o = (oq_cnt_q == 3'd0);
  assign oq_wr   = en && vld_q[SG];
  assign oq_rd   = pop_i && !empty_o;
  assign pix_o   = oq_mem_q[oq_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_wr) oq_wp_q <= oq_wp_q + 2'd1;
      if (oq_rd) oq_rp_q <= oq_rp_q + 2'd1;
      if (oq_wr && !oq_rd) oq_cnt_q <= oq_cnt_q + 3'd1;
      else if (oq_rd && !oq_wr) oq_cnt_q <= oq_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) begin
      oq_mem_q[oq_wp_q] <= g_q;
    end
  end

endmodule : hsla_back

`default_nettype wire

// ===== design/hsl_pixel_adjust_core.sv =====
// Throughput: one pixel per cycle; the 17-stage divider pipeline and the
// multiplier stages behind it each take a new transaction every cycle,
// except while a full result queue stalls them.
// Reset: asynchronous, active low; queues empty, registers hue_shift,
// saturation_gain and lightness_gain cleared to zero.
`timescale 1ns / 1ps
`default_nettype none

module hsl_pixel_adjust_core
  import hsla_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire pix_in_t             pix_i,
  output logic                     empty,
  input  wire logic                pop,
  output pix_out_t                 pix_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic qpush, qfull, qpop, qempty;
  div_t qin, qout;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_HUE_SHIFT:  cfg_q.hue_shift       <= cfg_wdata_i;
        REG_SAT_GAIN:   cfg_q.saturation_gain <= cfg_wdata_i;
        REG_LIGHT_GAIN: cfg_q.lightness_gain  <= cfg_wdata_i;
        default:        cfg_q                 <= cfg_q;
      endcase
    end
  end

  hsla_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pix_i   (pix_i),
    .full_o  (full),
    .qpush_o (qpush),
    .qdata_o (qin),
    .qfull_i (qfull)
  );

  hsla_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qpush),
    .data_i  (qin),
    .full_o  (qfull),
    .pop_i   (qpop),
    .empty_o (qempty),
    .data_o  (qout)
  );

  hsla_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .qempty_i (qempty),
    .qdata_i  (qout),
    .qpop_o   (qpop),
    .empty_o  (empty),
    .pop_i    (pop),
    .pix_o    (pix_o)
  );

endmodule : hsl_pixel_adjust_core

`default_nettype wire

// ===== design/hsla_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsla_checker
  import hsla_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                push,
  input wire logic                full,
  input wire pix_in_t             pix_i,
  input wire logic                empty,
  input wire logic                pop,
  input wire pix_out_t            pix_o,
  input wire logic                cfg_we_i,
  input wire logic [CfgAddrW-1:0] cfg_addr_i,
  input wire logic [CfgDataW-1:0] cfg_wdata_i
);

  // no result can come out of the pipeline right after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> empty ##1 empty ##1 empty)
    else $error("result seen too soon after reset");

  // input side is open right after reset
  a_open_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !full)
    else $error("full asserted right after reset");

  // a waiting result holds until popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pix_o)))
    else $error("waiting result changed");

endmodule : hsla_checker

bind hsl_pixel_adjust_core hsla_checker u_chk (.*);

`default_nettype wire
